FILE: rtl/cascaded_biquad_equalizer_assert.svh
// Assertion macros used by the equalizer controller RTL
`ifndef CASCADED_BIQUAD_EQUALIZER_ASSERT_SVH
`define CASCADED_BIQUAD_EQUALIZER_ASSERT_SVH

// The condition must never hold at a clock edge outside reset
`define CBQ_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("equalizer assertion failed");

// The consequent must hold in the cycle after the antecedent
`define CBQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("equalizer assertion failed");

`endif

FILE: rtl/cbq_pkg.sv
// Types and constants shared by the cascaded biquad equalizer
`timescale 1ns / 1ps
package cbq_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int COEF_FRAC   = 20;
    localparam int COEF_SLOTS  = 5;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + 3;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_COEF   = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    localparam logic CFG_ACTIVE_STAGES = 1'b0;
    localparam logic CFG_EFFECT_ENABLE = 1'b1;

    localparam logic signed [ACC_BITS-1:0] ACC_SAT_HI =
        ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] ACC_SAT_LO = ~ACC_SAT_HI;
    localparam logic signed [ACC_BITS-1:0] ACC_RND =
        ACC_BITS'(64'sd1 <<< (COEF_FRAC - 1));

    typedef struct packed {
        logic [1:0]                    req_type;
        logic                          channel;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          block_end;
        logic [2:0]                    coef_stage;
        logic [2:0]                    coef_slot;
        logic signed [COEF_BITS-1:0]   coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          channel_out;
        logic                          block_end_out;
    } out_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
    } hist_row_t;

    typedef struct packed {
        logic       take_sample;
        logic       coef_wr;
        logic       flush;
        logic       rd;
        logic       acc_clr;
        logic       mul_en;
        logic [2:0] mul_k;
        logic       acc_en;
        logic       wb;
        logic       load_out;
    } cmd_t;

endpackage

FILE: rtl/cascaded_biquad_equalizer.sv
// Each sample passes through N stages, N = active stages (clamped), then the output register.
// Each stage runs on the single shared 24x24 multiplier (read, 5 MACs, drain, write).
// No new item is taken until a sample is done; coefficient writes and flushes do not leave idle.
// The output register lets a new item be taken while a result waits.
// Reset clears history and coefficients at once through valid bits; no clearing pass.
`timescale 1ns / 1ps
module cascaded_biquad_equalizer
    import cbq_pkg::*;
#(
    parameter int MAX_STAGES = 8,
    parameter int CHANNELS   = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [3:0] cfg_data
);

    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int NW = $clog2(MAX_STAGES + 1);

    cmd_t          cmd;
    logic [SW-1:0] stage;
    logic [NW-1:0] n_stages;

    cbq_ctrl #(
        .MAX_STAGES (MAX_STAGES),
        .CHANNELS   (CHANNELS),
        .SW         (SW),
        .NW         (NW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .n_stages  (n_stages),
        .cmd       (cmd),
        .stage     (stage)
    );

    cbq_dp #(
        .MAX_STAGES (MAX_STAGES),
        .CHANNELS   (CHANNELS),
        .SW         (SW),
        .NW         (NW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stage     (stage),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_stages  (n_stages),
        .out_data  (out_data)
    );

endmodule

FILE: rtl/cbq_dp.sv
// Equalizer datapath: coefficient and history memories, shared MAC, output register
`timescale 1ns / 1ps
module cbq_dp
    import cbq_pkg::*;
#(
    parameter int MAX_STAGES = 8,
    parameter int CHANNELS   = 2,
    parameter int SW         = 3,
    parameter int NW         = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  in_item_t        in_data,
    input  cmd_t            cmd,
    input  logic [SW-1:0]   stage,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [3:0]      cfg_data,
    output logic [NW-1:0]   n_stages,
    output out_item_t       out_data
);

    localparam int ROWS = CHANNELS * MAX_STAGES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [3:0] active_reg;
    logic       enable_reg;

    logic signed [COEF_BITS-1:0] coef_mem [COEF_SLOTS][MAX_STAGES];
    logic                        coef_vld_reg [COEF_SLOTS][MAX_STAGES];
    hist_row_t                   hist_mem [ROWS];
    logic [ROWS-1:0]             hist_vld_reg;

    logic signed [COEF_BITS-1:0] coef_rd_reg [COEF_SLOTS];
    logic                        coef_rv_reg [COEF_SLOTS];
    hist_row_t                   hist_rd_reg;
    logic                        hist_rv_reg;

    logic signed [SAMPLE_BITS-1:0] v_reg;
    logic signed [SAMPLE_BITS-1:0] x0_reg;
    logic                          ch_reg;
    logic                          be_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic                          sub_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    out_item_t                     out_reg;

    logic                          coef_ok;
    logic [SW-1:0]                 cw_stage;
    logic [RW-1:0]                 row;
    hist_row_t                     hist_eff;
    hist_row_t                     hist_wr;
    logic signed [COEF_BITS-1:0]   coef_sel;
    logic signed [SAMPLE_BITS-1:0] opnd_sel;
    logic signed [ACC_BITS-1:0]    rnd;
    logic signed [ACC_BITS-1:0]    shifted;
    logic signed [SAMPLE_BITS-1:0] y;

    assign n_stages = (32'(active_reg) > MAX_STAGES) ? NW'(MAX_STAGES) : NW'(active_reg);

    assign coef_ok  = (32'(in_data.coef_stage) < MAX_STAGES) && (in_data.coef_slot <= SLOT_A2);
    assign cw_stage = SW'(in_data.coef_stage);
    assign row      = RW'(32'(ch_reg) * MAX_STAGES + 32'(stage));

    assign hist_eff = hist_rv_reg ? hist_rd_reg : '0;

    always_comb
    begin
        coef_sel = coef_rv_reg[SLOT_B0] ? coef_rd_reg[SLOT_B0] : '0;
        opnd_sel = '0;
        case (cmd.mul_k)
            SLOT_B0:
            begin
                coef_sel = coef_rv_reg[SLOT_B0] ? coef_rd_reg[SLOT_B0] : '0;
                opnd_sel = v_reg;
            end
            SLOT_B1:
            begin
                coef_sel = coef_rv_reg[SLOT_B1] ? coef_rd_reg[SLOT_B1] : '0;
                opnd_sel = hist_eff.x1;
            end
            SLOT_B2:
            begin
                coef_sel = coef_rv_reg[SLOT_B2] ? coef_rd_reg[SLOT_B2] : '0;
                opnd_sel = hist_eff.x2;
            end
            SLOT_A1:
            begin
                coef_sel = coef_rv_reg[SLOT_A1] ? coef_rd_reg[SLOT_A1] : '0;
                opnd_sel = hist_eff.y1;
            end
            SLOT_A2:
            begin
                coef_sel = coef_rv_reg[SLOT_A2] ? coef_rd_reg[SLOT_A2] : '0;
                opnd_sel = hist_eff.y2;
            end
            default:
            begin
                coef_sel = '0;
                opnd_sel = '0;
            end
        endcase
    end

    // round half up, floor shift, saturate
    assign rnd     = acc_reg + ACC_RND;
    assign shifted = rnd >>> COEF_FRAC;
    assign y = (shifted > ACC_SAT_HI) ? ACC_SAT_HI[SAMPLE_BITS-1:0] :
               (shifted < ACC_SAT_LO) ? ACC_SAT_LO[SAMPLE_BITS-1:0] :
               shifted[SAMPLE_BITS-1:0];

    always_comb
    begin
        hist_wr.x1 = v_reg;
        hist_wr.x2 = hist_eff.x1;
        hist_wr.y1 = y;
        hist_wr.y2 = hist_eff.y1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACTIVE_STAGES: active_reg <= cfg_data;
                CFG_EFFECT_ENABLE: enable_reg <= cfg_data[0];
                default:           active_reg <= active_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < COEF_SLOTS; k++)
            begin
                for (int s = 0; s < MAX_STAGES; s++)
                begin
                    coef_vld_reg[k][s] <= 1'b0;
                end
            end
            hist_vld_reg <= '0;
        end
        else
        begin
            if (cmd.coef_wr && coef_ok)
            begin
                coef_vld_reg[in_data.coef_slot][cw_stage] <= 1'b1;
            end
            if (cmd.flush)
            begin
                hist_vld_reg <= '0;
            end
            else if (cmd.wb)
            begin
                hist_vld_reg[row] <= 1'b1;
            end
        end
    end

    // memories and registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.coef_wr && coef_ok)
        begin
            coef_mem[in_data.coef_slot][cw_stage] <= in_data.coef_value;
        end
        if (cmd.wb)
        begin
            hist_mem[row] <= hist_wr;
        end
        if (cmd.rd)
        begin
            for (int k = 0; k < COEF_SLOTS; k++)
            begin
                coef_rd_reg[k] <= coef_mem[k][stage];
                coef_rv_reg[k] <= coef_vld_reg[k][stage];
            end
            hist_rd_reg <= hist_mem[row];
            hist_rv_reg <= hist_vld_reg[row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_sample)
        begin
            v_reg  <= in_data.sample_in;
            x0_reg <= in_data.sample_in;
            ch_reg <= in_data.channel;
            be_reg <= in_data.block_end;
        end
        else if (cmd.wb)
        begin
            v_reg <= y;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= coef_sel * opnd_sel;
            sub_reg  <= (cmd.mul_k == SLOT_A1) || (cmd.mul_k == SLOT_A2);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= sub_reg ? acc_reg - ACC_BITS'(prod_reg) : acc_reg + ACC_BITS'(prod_reg);
        end
        if (cmd.load_out)
        begin
            out_reg.sample_out    <= enable_reg ? v_reg : x0_reg;
            out_reg.channel_out   <= ch_reg;
            out_reg.block_end_out <= be_reg;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: rtl/cbq_ctrl.sv
// Equalizer controller: request decode, stage and MAC sequencing, output handshake
`timescale 1ns / 1ps
module cbq_ctrl
    import cbq_pkg::*;
#(
    parameter int MAX_STAGES = 8,
    parameter int CHANNELS   = 2,
    parameter int SW         = 3,
    parameter int NW         = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  in_item_t      in_data,
    output logic          out_valid,
    input  logic          out_stall,
    input  logic [NW-1:0] n_stages,
    output cmd_t          cmd,
    output logic [SW-1:0] stage
);

    `include "cascaded_biquad_equalizer_assert.svh"

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_WB    = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [SW-1:0] stage_reg, stage_next;
    logic [2:0]    k_reg, k_next;
    logic          out_valid_reg, out_valid_next;

    logic accept;
    logic is_sample;
    logic last_stage;
    logic out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign is_sample = (in_data.req_type == REQ_SAMPLE) && (32'(in_data.channel) < CHANNELS);
    assign last_stage = (32'(stage_reg) + 1 >= 32'(n_stages));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.mul_k      = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.coef_wr = (in_data.req_type == REQ_COEF);
                    cmd.flush   = (in_data.req_type == REQ_FLUSH);
                    if (is_sample)
                    begin
                        cmd.take_sample = 1'b1;
                        stage_next      = '0;
                        state_next      = (n_stages == '0) ? ST_OUT : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd      = 1'b1;
                cmd.acc_clr = 1'b1;
                k_next      = SLOT_B0;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                // product of the previous term lands while the next one multiplies
                cmd.mul_en = 1'b1;
                cmd.acc_en = (k_reg != SLOT_B0);
                k_next     = k_reg + 3'd1;
                if (k_reg == SLOT_A2)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.acc_en = 1'b1;
                state_next = ST_WB;
            end
            ST_WB:
            begin
                cmd.wb = 1'b1;
                if (last_stage)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign stage     = stage_reg;

    `CBQ_ASSERT_NEVER(a_no_overwrite, cmd.load_out && out_valid_reg && out_stall)
    `CBQ_ASSERT_NEVER(a_stage_range, (state_reg == ST_READ) && (32'(stage_reg) >= 32'(n_stages)))
    `CBQ_ASSERT_NEXT(a_sample_starts, cmd.take_sample && (n_stages != '0), state_reg == ST_READ)
    `CBQ_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_reg)

endmodule

FILE: dv/cascaded_biquad_equalizer_checker.sv
// Response checker for the cascaded biquad equalizer: predicts results and compares them
`timescale 1ns / 1ps
module cascaded_biquad_equalizer_checker
    import cbq_pkg::*;
#(
    parameter int MAX_STAGES = 8,
    parameter int CHANNELS   = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [3:0] cfg_data,
    output int        errors,
    output int        pending,
    output int        results_seen
);

    logic signed [COEF_BITS-1:0]   coefs [MAX_STAGES][COEF_SLOTS];
    logic signed [SAMPLE_BITS-1:0] xh [CHANNELS][MAX_STAGES][2];
    logic signed [SAMPLE_BITS-1:0] yh [CHANNELS][MAX_STAGES][2];
    logic [3:0] n_stages;
    logic       enabled;
    out_item_t  expected_q [$];

    assign pending = expected_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] biquad(int ch, int st,
                                                            logic signed [SAMPLE_BITS-1:0] x);
        longint acc;
        longint r;
        acc = longint'(coefs[st][SLOT_B0]) * x + longint'(coefs[st][SLOT_B1]) * xh[ch][st][0]
            + longint'(coefs[st][SLOT_B2]) * xh[ch][st][1]
            - longint'(coefs[st][SLOT_A1]) * yh[ch][st][0]
            - longint'(coefs[st][SLOT_A2]) * yh[ch][st][1];
        r = (acc + (64'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (r > 64'sd8388607)
            r = 64'sd8388607;
        else if (r < -64'sd8388608)
            r = -64'sd8388608;
        xh[ch][st][1] = xh[ch][st][0];
        xh[ch][st][0] = x;
        yh[ch][st][1] = yh[ch][st][0];
        yh[ch][st][0] = r[SAMPLE_BITS-1:0];
        return r[SAMPLE_BITS-1:0];
    endfunction

    task automatic clear_history();
        foreach (xh[c, s, k])
        begin
            xh[c][s][k] = '0;
            yh[c][s][k] = '0;
        end
    endtask

    task automatic equalize(in_item_t it);
        logic signed [SAMPLE_BITS-1:0] v;
        out_item_t r;
        int n;
        case (it.req_type)
            REQ_COEF:
                if (it.coef_stage < MAX_STAGES && it.coef_slot < COEF_SLOTS)
                    coefs[it.coef_stage][it.coef_slot] = it.coef_value;
            REQ_FLUSH:
                clear_history();
            REQ_SAMPLE:
                if (it.channel < CHANNELS)
                begin
                    v = it.sample_in;
                    n = (n_stages > MAX_STAGES) ? MAX_STAGES : n_stages;
                    for (int s = 0; s < n; s++)
                        v = biquad(it.channel, s, v);
                    r.sample_out = enabled ? v : it.sample_in;
                    r.channel_out = it.channel;
                    r.block_end_out = it.block_end;
                    expected_q.push_back(r);
                end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t w;
        if (!rst_n)
        begin
            foreach (coefs[s, k])
                coefs[s][k] = '0;
            clear_history();
            n_stages = '0;
            enabled = 1'b1;
            errors = 0;
            results_seen = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ACTIVE_STAGES)
                    n_stages = cfg_data;
                else
                    enabled = cfg_data[0];
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    report("unexpected result", 32'(out_data), 32'd0);
                else
                begin
                    w = expected_q.pop_front();
                    if (out_data.sample_out !== w.sample_out)
                        report("sample_out", 32'(out_data.sample_out), 32'(w.sample_out));
                    if (out_data.channel_out !== w.channel_out)
                        report("channel_out", 32'(out_data.channel_out),
                               32'(w.channel_out));
                    if (out_data.block_end_out !== w.block_end_out)
                        report("block_end_out", 32'(out_data.block_end_out),
                               32'(w.block_end_out));
                end
            end
            if (in_valid && !in_stall)
                equalize(in_data);
        end
    end

endmodule

FILE: dv/cascaded_biquad_equalizer_tb.sv
// Testbench top for the cascaded biquad equalizer: stimulus, idling and verdict
`timescale 1ns / 1ps
module cascaded_biquad_equalizer_tb;
    import cbq_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic      cfg_index = CFG_ACTIVE_STAGES;
    logic [3:0] cfg_data = '0;
    int        errors;
    int        pending;
    int        results_seen;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_off = 1'b0;
    int        cycles = 0;
    int        sent = 0;

    always #2 clk = ~clk;

    cascaded_biquad_equalizer dut (.*);

    cascaded_biquad_equalizer_checker chk (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("cascaded_biquad_equalizer: mismatch");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);

    // Send one item; hold it until its transfer, leave valid to the next caller
    task automatic send(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    function automatic in_item_t mk(logic [1:0] rt, logic ch, logic [23:0] smp, logic be,
                                    logic [2:0] st, logic [2:0] sl, logic [23:0] cv);
        in_item_t it;
        it.req_type = rt;
        it.channel = ch;
        it.sample_in = smp;
        it.block_end = be;
        it.coef_stage = st;
        it.coef_slot = sl;
        it.coef_value = cv;
        return it;
    endfunction

    function automatic in_item_t rand_item();
        return mk(2'($urandom_range(3)), 1'($urandom), 24'($urandom), 1'($urandom),
                  3'($urandom), 3'($urandom), 24'($urandom));
    endfunction

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(3))
            0: return 24'h7fffff;
            1: return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    // Filter-shaped coefficients mostly within plus or minus unity, sometimes wild
    function automatic logic [23:0] rand_coef();
        if ($urandom_range(4) == 0)
            return 24'($urandom);
        return 24'($signed($urandom_range(2097152)) - 1048576);
    endfunction

    task automatic write_cfg(logic idx, logic [3:0] val);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_coefs();
        for (int s = 0; s < 8; s++)
            for (int k = 0; k < COEF_SLOTS; k++)
                send(mk(REQ_COEF, 1'b0, 24'($urandom), 1'b0, 3'(s), 3'(k), rand_coef()));
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                send(rand_item());
            else if ($urandom_range(19) == 0)
                send(mk(REQ_COEF, 1'b0, 24'd0, 1'b0, 3'($urandom), 3'($urandom_range(4)),
                        rand_coef()));
            else
                send(mk(REQ_SAMPLE, 1'($urandom), rand_sample(), 1'($urandom), 3'($urandom),
                        3'($urandom), 24'($urandom)));
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // Directed: zero stages passthrough, extremes, coefficient edge cases
        send(mk(REQ_SAMPLE, 0, 24'h7fffff, 1, 0, 0, 0));
        send(mk(REQ_SAMPLE, 1, 24'h800000, 0, 0, 0, 0));
        send(mk(REQ_SAMPLE, 1, 24'h000000, 1, 7, 7, 24'hffffff));
        send(mk(REQ_COEF, 0, 0, 0, 0, SLOT_B0, 24'h7fffff));
        send(mk(REQ_COEF, 0, 0, 0, 0, 3'd5, 24'h123456));
        send(mk(REQ_COEF, 0, 0, 0, 0, 3'd7, 24'h800000));
        send(mk(REQ_COEF, 0, 0, 0, 0, SLOT_A1, 24'h800000));
        send(mk(REQ_COEF, 0, 0, 0, 7, SLOT_A2, 24'h100000));
        send(mk(2'd3, 0, 24'h123456, 1, 0, 0, 0));
        write_cfg(CFG_ACTIVE_STAGES, 4'd1);
        send(mk(REQ_SAMPLE, 0, 24'h7fffff, 0, 0, 0, 0));
        send(mk(REQ_SAMPLE, 0, 24'h800000, 1, 0, 0, 0));
        send(mk(REQ_SAMPLE, 1, 24'h7fffff, 0, 0, 0, 0));
        send(mk(REQ_FLUSH, 0, 0, 0, 0, 0, 0));
        send(mk(REQ_SAMPLE, 0, 24'h000001, 0, 0, 0, 0));
        write_cfg(CFG_EFFECT_ENABLE, 4'd0);
        send(mk(REQ_SAMPLE, 0, 24'h400000, 1, 0, 0, 0));
        send(mk(REQ_SAMPLE, 1, 24'hc00000, 0, 0, 0, 0));
        write_cfg(CFG_EFFECT_ENABLE, 4'd1);
        write_cfg(CFG_ACTIVE_STAGES, 4'd15);
        load_coefs();
        send(mk(REQ_SAMPLE, 1, 24'h7fffff, 1, 0, 0, 0));
        send(mk(REQ_SAMPLE, 0, 24'h800000, 0, 0, 0, 0));

        // Random phases over several settings
        send_idle_pct = 7;
        recv_idle_pct = 47;
        write_cfg(CFG_ACTIVE_STAGES, 4'd2);
        random_phase(120);
        write_cfg(CFG_EFFECT_ENABLE, 4'd0);
        write_cfg(CFG_ACTIVE_STAGES, 4'd8);
        random_phase(60);
        send_idle_pct = 47;
        recv_idle_pct = 7;
        write_cfg(CFG_EFFECT_ENABLE, 4'd1);
        write_cfg(CFG_ACTIVE_STAGES, 4'd0);
        random_phase(60);
        write_cfg(CFG_ACTIVE_STAGES, 4'd3);
        load_coefs();
        random_phase(100);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(CFG_ACTIVE_STAGES, 4'd1);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(40);
        join
        write_cfg(CFG_ACTIVE_STAGES, 4'd9);
        random_phase(100);
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        $display("sent %0d items, checked %0d results over stage counts 0 to 15,", sent,
                 results_seen);
        $display("filter on and off, with flushes, coefficient writes and stalls");
        if (errors == 0)
            $display("cascaded_biquad_equalizer: match");
        else
            $display("cascaded_biquad_equalizer: mismatch");
        $finish;
    end

endmodule
